/* src/acs_pkg.sv */
// shared types, constants and shaping functions for the arabic contextual shaper
`default_nettype none

package acs_pkg;

  localparam int CP_W   = 21;
  localparam int FORM_W = 16;

  // range of code points that may be shaped
  localparam logic [CP_W-1:0] LETTER_FIRST = 21'h00_0622;
  localparam logic [CP_W-1:0] LETTER_LAST  = 21'h00_064A;

  // alef maqsura has its own initial and medial forms
  localparam logic [FORM_W-1:0] MAQSURA_ISO  = 16'hFEEF;
  localparam logic [FORM_W-1:0] MAQSURA_INIT = 16'hFBE8;

  // context offsets from the isolated form
  localparam logic [1:0] CTX_ISOLATED = 2'd0;
  localparam logic [1:0] CTX_FINAL    = 2'd1;
  localparam logic [1:0] CTX_INITIAL  = 2'd2;
  localparam logic [1:0] CTX_MEDIAL   = 2'd3;

  // isolated form for U+0622..U+064A, zero where the code point is not shaped
  localparam logic [FORM_W-1:0] ISO_TABLE [0:40] = '{
    16'hFE81, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFE8D, 16'hFE8F, 16'hFE93,
    16'hFE95, 16'hFE99, 16'hFE9D, 16'hFEA1, 16'hFEA5, 16'hFEA9, 16'hFEAB, 16'hFEAD,
    16'hFEAF, 16'hFEB1, 16'hFEB5, 16'hFEB9, 16'hFEBD, 16'hFEC1, 16'hFEC5, 16'hFEC9,
    16'hFECD, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFED1,
    16'hFED5, 16'hFED9, 16'hFEDD, 16'hFEE1, 16'hFEE5, 16'hFEE9, 16'hFEED, 16'hFEEF,
    16'hFEF1
  };

  // one queued item: one or two glyphs
  typedef struct packed {
    logic [CP_W-1:0] glyph0;
    logic [CP_W-1:0] glyph1;
    logic            two_beats;
    logic            eot;
  } acs_entry_t;

  // front to queue write side
  typedef struct packed {
    logic       push;
    acs_entry_t entry;
  } acs_qwr_t;

  // queue status toward both sides
  typedef struct packed {
    logic not_empty;
    logic full;
  } acs_qstat_t;

  function automatic logic [FORM_W-1:0] to_iso(input logic [CP_W-1:0] cp);
    logic [CP_W-1:0]   off;
    logic [FORM_W-1:0] res;
    off = cp - LETTER_FIRST;
    if (cp < LETTER_FIRST || cp > LETTER_LAST) begin
      res = '0;
    end else begin
      res = ISO_TABLE[off[5:0]];
    end
    return res;
  endfunction

  function automatic logic is_right_joining(input logic [FORM_W-1:0] iso);
    return iso inside {16'hFE81, 16'hFE8D, 16'hFEA9, 16'hFEAB,
                       16'hFEAD, 16'hFEAF, 16'hFEED, 16'hFE93};
  endfunction

  function automatic logic [FORM_W-1:0] shape(input logic [FORM_W-1:0] iso,
                                              input logic [1:0] ctx);
    logic [FORM_W-1:0] res;
    if (iso == MAQSURA_ISO && (ctx == CTX_INITIAL || ctx == CTX_MEDIAL)) begin
      res = MAQSURA_INIT + {{(FORM_W-1){1'b0}}, ctx[0]};
    end else begin
      res = iso + {{(FORM_W-2){1'b0}}, ctx};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* src/acs_ifs.sv */
// valid/ready channel interfaces for code points in and glyphs out
`default_nettype none

interface acs_in_if import acs_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] code_point;
  logic            end_of_text;

  modport source (output valid, output code_point, output end_of_text, input ready);
  modport sink   (input valid, input code_point, input end_of_text, output ready);
endinterface

interface acs_out_if import acs_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] glyph;
  logic            last_of_item;
  logic            text_done;

  modport source (output valid, output glyph, output last_of_item, output text_done,
                  input ready);
  modport sink   (input valid, input glyph, input last_of_item, input text_done,
                  output ready);
endinterface

`default_nettype wire

/* src/arabic_contextual_shaper.sv */
// top level of the arabic contextual shaper: front end, item queue, output side
//
//   channel  dir  handshake          beat
//   in_s     in   valid/ready        code_point, end_of_text
//   out_m    out  valid/ready        glyph, last_of_item, text_done
//
// an item is taken every cycle while the queue has room; the item is classified
// and its held letter resolved in the cycle it is accepted
// the single output register gives one glyph a cycle while the receiver is ready,
// so an item that releases two glyphs gives two beats; a held letter alone gives none
// the queue of QUEUE_DEPTH entries lets input and output stall on their own
// synchronous active-low reset clears the held letter, queue and output valid
`default_nettype none

module arabic_contextual_shaper import acs_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  acs_in_if.sink    in_s,
  acs_out_if.source out_m
);

  acs_qwr_t   qwr;
  acs_qstat_t qstat;
  acs_entry_t head;
  logic       pop;

  // classify and hold
  acs_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_s),
    .qstat (qstat),
    .qwr   (qwr)
  );

  // decoupling queue
  acs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .qwr   (qwr),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  // glyph beats out
  acs_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .head  (head),
    .qstat (qstat),
    .pop   (pop),
    .out_m (out_m)
  );

endmodule

`default_nettype wire

/* src/acs_front.sv */
// front end: classifies each code point, tracks the held letter, builds queue entries
`default_nettype none

module acs_front import acs_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  acs_in_if.sink          in_s,
  input  wire acs_qstat_t qstat,
  output acs_qwr_t        qwr
);

  logic [FORM_W-1:0] held_letter_r, held_letter_nxt;
  logic              held_valid_r, held_valid_nxt;
  logic              held_starts_r, held_starts_nxt;

  logic              accept;
  logic [FORM_W-1:0] iso;
  logic              is_letter;
  logic              is_dual;
  logic [FORM_W-1:0] rel_end;
  logic [FORM_W-1:0] rel_join;
  logic [CP_W-1:0]   cur_glyph;

  assign in_s.ready = !qstat.full;
  assign accept     = in_s.valid && in_s.ready;

  // classify the incoming code point
  always_comb begin
    iso       = to_iso(in_s.code_point);
    is_letter = (iso != '0);
    is_dual   = is_letter && !is_right_joining(iso);
    rel_end   = shape(held_letter_r, held_starts_r ? CTX_ISOLATED : CTX_FINAL);
    rel_join  = shape(held_letter_r, held_starts_r ? CTX_INITIAL : CTX_MEDIAL);
    cur_glyph = is_letter ?
                {{(CP_W-FORM_W){1'b0}}, shape(iso, held_valid_r ? CTX_FINAL : CTX_ISOLATED)} :
                in_s.code_point;
  end

  // queue entry: released held letter first, then the current glyph
  always_comb begin
    qwr.push            = accept && (held_valid_r || !is_dual || in_s.end_of_text);
    qwr.entry.two_beats = held_valid_r && (!is_dual || in_s.end_of_text);
    qwr.entry.eot       = in_s.end_of_text;
    qwr.entry.glyph1    = cur_glyph;
    if (held_valid_r) begin
      qwr.entry.glyph0 = {{(CP_W-FORM_W){1'b0}}, is_letter ? rel_join : rel_end};
    end else begin
      qwr.entry.glyph0 = cur_glyph;
    end
  end

  // held letter update
  always_comb begin
    held_letter_nxt = held_letter_r;
    held_valid_nxt  = held_valid_r;
    held_starts_nxt = held_starts_r;
    if (accept) begin
      if (is_dual && !in_s.end_of_text) begin
        held_letter_nxt = iso;
        held_valid_nxt  = 1'b1;
        held_starts_nxt = !held_valid_r;
      end else begin
        held_letter_nxt = '0;
        held_valid_nxt  = 1'b0;
        held_starts_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_letter_r <= '0;
      held_valid_r  <= 1'b0;
      held_starts_r <= 1'b0;
    end else begin
      held_letter_r <= held_letter_nxt;
      held_valid_r  <= held_valid_nxt;
      held_starts_r <= held_starts_nxt;
    end
  end

`ifndef ASSERT_OFF
  // the end of a text always leaves nothing held
  a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_s.end_of_text |=> !held_valid_r)
    else $error("letter still held after end of text");

  // a beat that ends a text is always pushed
  a_eot_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_s.end_of_text |-> qwr.push)
    else $error("end of text gave no queue entry");
`endif

endmodule

`default_nettype wire

/* src/acs_queue.sv */
// short queue of shaped items between front end and output side
`default_nettype none

module acs_queue import acs_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire acs_qwr_t qwr,
  input  wire logic     pop,
  output acs_entry_t    head,
  output acs_qstat_t    qstat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  acs_entry_t       entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_pop;

  assign qstat.not_empty = (count_r != '0);
  assign qstat.full      = (count_r == FULL_CNT);
  assign head            = entries_r[rd_ptr_r];
  assign do_pop          = pop && qstat.not_empty;

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (qwr.push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (qwr.push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!qwr.push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (qwr.push) begin
      entries_r[wr_ptr_r] <= qwr.entry;
    end
  end

`ifndef ASSERT_OFF
  // fill count stays within the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("queue count beyond depth");

  // front end never writes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(qwr.push && qstat.full))
    else $error("push into full queue");
`endif

endmodule

`default_nettype wire

/* src/acs_back.sv */
// output side: splits queued items into glyph beats behind an output register
`default_nettype none

module acs_back import acs_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire acs_entry_t head,
  input  wire acs_qstat_t qstat,
  output logic            pop,
  acs_out_if.source       out_m
);

  logic            out_valid_r, out_valid_nxt;
  logic            phase_r, phase_nxt;
  logic [CP_W-1:0] glyph_r;
  logic            last_r;
  logic            done_r;
  logic            load;
  logic            beat_last;

  assign out_m.valid        = out_valid_r;
  assign out_m.glyph        = glyph_r;
  assign out_m.last_of_item = last_r;
  assign out_m.text_done    = done_r;

  // load the next beat when the output register is free or draining
  always_comb begin
    load          = qstat.not_empty && (!out_valid_r || out_m.ready);
    beat_last     = phase_r || !head.two_beats;
    pop           = load && beat_last;
    phase_nxt     = load ? !beat_last : phase_r;
    out_valid_nxt = load ? 1'b1 : (out_m.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  // beat payload
  always_ff @(posedge clk) begin
    if (load) begin
      glyph_r <= phase_r ? head.glyph1 : head.glyph0;
      last_r  <= beat_last;
      done_r  <= head.eot && beat_last;
    end
  end

`ifndef ASSERT_OFF
  // second beat pending means its entry is still queued
  a_phase_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> qstat.not_empty)
    else $error("second beat pending with empty queue");

  // text end only on the closing beat of an item
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && done_r |-> last_r)
    else $error("text_done without last_of_item");
`endif

endmodule

`default_nettype wire

/* tb/sv/arabic_contextual_shaper_tb.sv */
// self-checking testbench for the arabic contextual shaper: directed texts, random text streams
`timescale 1ns / 1ps

module arabic_contextual_shaper_tb;
  import acs_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;

  // one expected glyph beat
  typedef struct packed {
    logic [CP_W-1:0] glyph;
    logic            last_of_item;
    logic            text_done;
  } glyph_beat_t;

  logic clk;
  logic rst_n;

  acs_in_if  in_b ();
  acs_out_if out_b ();

  arabic_contextual_shaper uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_b),
    .out_m (out_b)
  );

  // shaping state of the predictor
  logic [FORM_W-1:0] held_form;
  logic              held_on;
  logic              held_word_start;

  glyph_beat_t glyphs_due[$];
  int          errors;
  int          quiet_cycles;

  // idling controls shared by the test tasks and the receiver
  bit tx_idle;
  bit rx_idle;
  bit rx_hold_ask;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // isolated presentation form of a basic letter, zero for anything else
  function automatic logic [FORM_W-1:0] iso_of(input logic [CP_W-1:0] cp);
    logic [FORM_W-1:0] f;
    case (cp)
      21'h000622: f = 16'hFE81;
      21'h000627: f = 16'hFE8D;
      21'h000628: f = 16'hFE8F;
      21'h000629: f = 16'hFE93;
      21'h00062A: f = 16'hFE95;
      21'h00062B: f = 16'hFE99;
      21'h00062C: f = 16'hFE9D;
      21'h00062D: f = 16'hFEA1;
      21'h00062E: f = 16'hFEA5;
      21'h00062F: f = 16'hFEA9;
      21'h000630: f = 16'hFEAB;
      21'h000631: f = 16'hFEAD;
      21'h000632: f = 16'hFEAF;
      21'h000633: f = 16'hFEB1;
      21'h000634: f = 16'hFEB5;
      21'h000635: f = 16'hFEB9;
      21'h000636: f = 16'hFEBD;
      21'h000637: f = 16'hFEC1;
      21'h000638: f = 16'hFEC5;
      21'h000639: f = 16'hFEC9;
      21'h00063A: f = 16'hFECD;
      21'h000641: f = 16'hFED1;
      21'h000642: f = 16'hFED5;
      21'h000643: f = 16'hFED9;
      21'h000644: f = 16'hFEDD;
      21'h000645: f = 16'hFEE1;
      21'h000646: f = 16'hFEE5;
      21'h000647: f = 16'hFEE9;
      21'h000648: f = 16'hFEED;
      21'h000649: f = 16'hFEEF;
      21'h00064A: f = 16'hFEF1;
      default:    f = '0;
    endcase
    return f;
  endfunction

  // letters that never join to the following letter
  function automatic bit joins_right_only(input logic [FORM_W-1:0] iso);
    bit r;
    case (iso)
      16'hFE81, 16'hFE8D, 16'hFEA9, 16'hFEAB,
      16'hFEAD, 16'hFEAF, 16'hFEED, 16'hFE93: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // contextual form; alef maqsura has its own initial and medial forms
  function automatic logic [CP_W-1:0] form_of(input logic [FORM_W-1:0] iso,
                                               input logic [1:0] ctx);
    logic [FORM_W-1:0] g;
    if (iso == MAQSURA_ISO && (ctx == CTX_INITIAL || ctx == CTX_MEDIAL)) begin
      g = (ctx == CTX_INITIAL) ? MAQSURA_INIT : MAQSURA_INIT + 16'd1;
    end else begin
      g = iso + {14'd0, ctx};
    end
    return {5'd0, g};
  endfunction

  function automatic glyph_beat_t beat_of(input logic [CP_W-1:0] g);
    glyph_beat_t b;
    b.glyph        = g;
    b.last_of_item = 1'b0;
    b.text_done    = 1'b0;
    return b;
  endfunction

  // work out the glyphs released by one accepted code point
  task automatic predict_glyphs(input logic [CP_W-1:0] cp, input logic eot);
    logic [FORM_W-1:0] iso;
    glyph_beat_t       beats[$];
    bit                was_held;
    iso      = iso_of(cp);
    was_held = held_on;
    if (iso == '0) begin
      if (held_on)
        beats.push_back(beat_of(form_of(held_form,
                                        held_word_start ? CTX_ISOLATED : CTX_FINAL)));
      beats.push_back(beat_of(cp));
      held_on         = 1'b0;
      held_word_start = 1'b0;
      held_form       = '0;
    end else if (joins_right_only(iso)) begin
      if (held_on)
        beats.push_back(beat_of(form_of(held_form,
                                        held_word_start ? CTX_INITIAL : CTX_MEDIAL)));
      beats.push_back(beat_of(form_of(iso, was_held ? CTX_FINAL : CTX_ISOLATED)));
      held_on         = 1'b0;
      held_word_start = 1'b0;
      held_form       = '0;
    end else begin
      if (held_on)
        beats.push_back(beat_of(form_of(held_form,
                                        held_word_start ? CTX_INITIAL : CTX_MEDIAL)));
      held_form       = iso;
      held_on         = 1'b1;
      held_word_start = !was_held;
    end
    // end of text flushes whatever is held
    if (eot) begin
      if (held_on)
        beats.push_back(beat_of(form_of(held_form,
                                        held_word_start ? CTX_ISOLATED : CTX_FINAL)));
      held_on         = 1'b0;
      held_word_start = 1'b0;
      held_form       = '0;
      if (beats.size() > 0)
        beats[beats.size()-1].text_done = 1'b1;
    end
    if (beats.size() > 0)
      beats[beats.size()-1].last_of_item = 1'b1;
    foreach (beats[i])
      glyphs_due.push_back(beats[i]);
  endtask

  // predictor fed by every accepted input beat
  always @(posedge clk) begin
    if (!rst_n) begin
      held_form       <= '0;
      held_on         <= 1'b0;
      held_word_start <= 1'b0;
    end else if (in_b.valid && in_b.ready) begin
      predict_glyphs(in_b.code_point, in_b.end_of_text);
    end
  end

  // compare each output beat with the oldest expected glyph
  always @(posedge clk) begin : check_glyphs
    glyph_beat_t want;
    if (rst_n && out_b.valid && out_b.ready) begin
      if (glyphs_due.size() == 0) begin
        $display("%0t: unexpected beat: expected none, actual glyph %h last %b done %b",
                 $time, out_b.glyph, out_b.last_of_item, out_b.text_done);
        errors++;
      end else begin
        want = glyphs_due.pop_front();
        if (out_b.glyph !== want.glyph) begin
          $display("%0t: glyph: expected %h, actual %h", $time, want.glyph, out_b.glyph);
          errors++;
        end
        if (out_b.last_of_item !== want.last_of_item) begin
          $display("%0t: last_of_item: expected %b, actual %b", $time,
                   want.last_of_item, out_b.last_of_item);
          errors++;
        end
        if (out_b.text_done !== want.text_done) begin
          $display("%0t: text_done: expected %b, actual %b", $time,
                   want.text_done, out_b.text_done);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (!rst_n || (in_b.valid && in_b.ready) || (out_b.valid && out_b.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap(input bit idle);
    int r;
    int g;
    r = $urandom_range(0, 99);
    if (!idle || r < 55)
      g = 0;
    else if (r < 90)
      g = $urandom_range(1, 3);
    else if (r < 98)
      g = $urandom_range(4, 12);
    else
      g = $urandom_range(20, 60);
    return g;
  endfunction

  // receiver: ready runs and gaps, plus one long hold on request
  initial begin : receiver
    int gap;
    out_b.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold_ask) begin
        rx_hold_ask = 1'b0;
        out_b.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = pick_gap(rx_idle);
      if (gap > 0) begin
        out_b.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_b.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // offer one code point and wait until it is taken
  task automatic send_cp(input logic [CP_W-1:0] cp, input logic eot);
    int gap;
    gap = pick_gap(tx_idle);
    if (gap > 0) begin
      in_b.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_b.valid       <= 1'b1;
    in_b.code_point  <= cp;
    in_b.end_of_text <= eot;
    do @(posedge clk); while (!in_b.ready);
  endtask

  // sender stops and waits for every expected glyph
  task automatic wait_drained();
    in_b.valid <= 1'b0;
    do @(posedge clk); while (glyphs_due.size() != 0);
  endtask

  // random text code point: mostly letter range unless noisy; some spaces, punctuation and others
  function automatic logic [CP_W-1:0] text_cp(input bit noisy);
    int r;
    logic [CP_W-1:0] cp;
    r = $urandom_range(0, 99);
    if (noisy && r < 50)
      cp = CP_W'($urandom_range(1, 21'h10FFFF));
    else if (r < 70)
      cp = CP_W'($urandom_range(21'h000622, 21'h00064A));
    else if (r < 80)
      cp = CP_W'($urandom_range(21'h000020, 21'h00007E));
    else if (r < 86)
      cp = CP_W'($urandom_range(21'h00FB50, 21'h00FEFF));
    else if (r < 90)
      cp = $urandom_range(0, 1) ? 21'h000621 : 21'h00064B;
    else
      cp = CP_W'($urandom_range(1, 21'h10FFFF));
    return cp;
  endfunction

  // stream of texts, each closed by end_of_text
  task automatic send_texts(input int count, input bit noisy);
    int sent;
    int len;
    int r;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(0, 99);
      if (r < 85)
        len = $urandom_range(1, 10);
      else if (r < 97)
        len = $urandom_range(11, 24);
      else
        len = $urandom_range(25, 40);
      if (len > count - sent)
        len = count - sent;
      for (int i = 0; i < len; i++)
        send_cp(text_cp(noisy), i == len - 1);
      sent += len;
    end
  endtask

  // forms, alef maqsura, right-joining letters, holes and extremes
  task automatic test_directed();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_cp(21'h000628, 1'b1);                               // lone letter
    send_cp(21'h000628, 1'b0);                               // initial, medial, final
    send_cp(21'h000628, 1'b0);
    send_cp(21'h000628, 1'b1);
    send_cp(21'h000649, 1'b0);                               // alef maqsura forms
    send_cp(21'h000649, 1'b0);
    send_cp(21'h000649, 1'b1);
    send_cp(21'h000649, 1'b1);
    send_cp(21'h000644, 1'b0);                               // lam then alef
    send_cp(21'h000627, 1'b0);
    send_cp(21'h000622, 1'b1);                               // alef madda after alef
    send_cp(21'h00064A, 1'b0);                               // held letter then space
    send_cp(21'h000020, 1'b1);
    send_cp(21'h000623, 1'b0);                               // holes and range bounds
    send_cp(21'h00063B, 1'b0);
    send_cp(21'h000640, 1'b0);
    send_cp(21'h000621, 1'b0);
    send_cp(21'h00064B, 1'b0);
    send_cp(21'h000001, 1'b0);
    send_cp(21'h10FFFF, 1'b0);
    send_cp(21'h00FE8F, 1'b1);                               // presentation form passes
    send_cp(21'h000633, 1'b0);                               // teh marbuta closes a word
    send_cp(21'h000629, 1'b1);
    send_cp(21'h000627, 1'b1);                               // lone right-joining letter
    wait_drained();
  endtask

  task automatic test_streaming();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_texts(400, 1'b0);
    wait_drained();
  endtask

  task automatic test_random_idle();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_texts(900, 1'b0);
    wait_drained();
  endtask

  // long receiver hold while the sender keeps offering, then a full drain and a pass with an idle sender
  task automatic test_backpressure();
    tx_idle     = 1'b0;
    rx_idle     = 1'b1;
    rx_hold_ask = 1'b1;
    send_texts(150, 1'b0);
    wait_drained();
    tx_idle = 1'b1;
    send_texts(150, 1'b0);
    wait_drained();
  endtask

  task automatic test_noise();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_texts(300, 1'b1);
    wait_drained();
  endtask

  initial begin
    errors           = 0;
    tx_idle          = 1'b0;
    rx_idle          = 1'b0;
    rx_hold_ask      = 1'b0;
    rst_n            <= 1'b0;
    in_b.valid       <= 1'b0;
    in_b.code_point  <= 21'h000001;
    in_b.end_of_text <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_streaming();
    test_random_idle();
    test_backpressure();
    test_noise();

    repeat (DRAIN_CYCLES) @(posedge clk);
    errors += glyphs_due.size();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* arabic_contextual_shaper.f */
src/acs_pkg.sv
src/acs_ifs.sv
src/acs_front.sv
src/acs_queue.sv
src/acs_back.sv
src/arabic_contextual_shaper.sv
tb/sv/arabic_contextual_shaper_tb.sv
